// File: rtl/core/dirty_range_tracker_assert.svh
// Assertion macros for the dirty range tracker checker.
// Each macro expects clk and arst_n in scope.
`ifndef DIRTY_RANGE_TRACKER_ASSERT_SVH
`define DIRTY_RANGE_TRACKER_ASSERT_SVH

// Same-cycle implication.
`define DRT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define DRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/drt_pkg.sv
package drt_pkg;

	localparam int MAX_RANGES = 16;
	localparam int PAGE_BITS  = 12;
	localparam int ADDR_BITS  = 32;

	// table index and fill count widths
	localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CNT_W = $clog2(MAX_RANGES + 1);

	// rounded end needs two bits above a 32-bit offset
	localparam int END_W = 34;

	localparam logic [END_W-1:0] PAGE_MASK = (END_W'(1) << PAGE_BITS) - END_W'(1);
	localparam logic [63:0]      SPACE_TOP = 64'd1 << ADDR_BITS;

	// command codes
	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_SYNC  = 2'd1;
	localparam logic [1:0] CMD_FLUSH = 2'd2;

	typedef enum logic [2:0] {
		ST_CONTAINED,
		ST_MERGED,
		ST_INSERTED,
		ST_FULL,
		ST_OUT_OF_RANGE,
		ST_RANGE,
		ST_EMPTY,
		ST_FLUSHED
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CALC,
		S_SEARCH,
		S_EMIT,
		S_SYNC_RD,
		S_SYNC_WAIT
	} state_t;

	// one result item
	typedef struct packed {
		status_t     status;
		logic [31:0] offset;
		logic [32:0] length;
		logic        wait_f;
		logic        last;
	} res_t;

	// table access request
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [31:0]      wstart;
		logic [END_W-1:0] wend;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

endpackage

// File: rtl/core/dirty_range_tracker.sv
// Add: the search reads one table entry per cycle from the range memory.
// Sync: for each recorded range, a memory read, then an output load.
// A new item is taken only once the previous one has loaded its last result.
// Reset clears image_base, the fill count and the output valid; range memory
//   contents stay undefined and need no clearing pass.
module dirty_range_tracker
	import drt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [31:0] address,
	input  logic [31:0] length,
	input  logic        wait_req,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] range_offset,
	output logic [32:0] range_length,
	output logic        wait_flag,
	output logic        last
);

	state_t state_q, state_d;

	logic [31:0]      base_q;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] rem_q, rem_d;
	logic             cmp_v_s1;
	logic [IDX_W-1:0] cmp_idx_s1;

	logic             below_q;
	logic [31:0]      rel_q;
	logic [31:0]      len_q;
	logic             wait_q;
	logic [31:0]      s_q;
	logic [END_W-1:0] e_q;
	res_t             res_q, res_d;
	logic             res_en;

	logic             accept;
	logic             slot_free;
	logic             out_load;
	res_t             out_res, load_res;
	mem_req_t         mreq;
	logic [31:0]      rd_start;
	logic [END_W-1:0] rd_end;

	logic [END_W-1:0] e_sum, e_c;
	logic [31:0]      s_c;
	logic             range_bad;
	logic             contain, touch, exhausted;
	logic [32:0]      add_len;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	// page rounding of the relative range
	assign e_sum     = END_W'(rel_q) + END_W'(len_q) + PAGE_MASK;
	assign e_c       = e_sum & ~PAGE_MASK;
	assign s_c       = rel_q & ~PAGE_MASK[31:0];
	assign range_bad = below_q || (64'(e_c) > SPACE_TOP);

	// compare of the entry read last cycle
	assign contain   = cmp_v_s1 && (rd_start <= s_q) && (e_q <= rd_end);
	assign touch     = cmp_v_s1 && (rd_end >= END_W'(s_q)) && (e_q >= END_W'(rd_start));
	assign exhausted = !cmp_v_s1 && (rem_q == '0);
	assign add_len   = 33'(e_q - END_W'(s_q));

	// next state, table access and result selection
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		rem_d    = rem_q;
		res_d    = res_q;
		res_en   = 1'b0;
		out_load = 1'b0;
		load_res = res_q;
		mreq     = '0;
		mreq.raddr = IDX_W'(rem_q - CNT_W'(1));
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (command)
						CMD_ADD: state_d = S_CALC;
						CMD_SYNC: begin
							rem_d   = count_q;
							state_d = S_SYNC_RD;
						end
						CMD_FLUSH: begin
							count_d = '0;
							res_d   = '{ST_FLUSHED, 32'd0, 33'd0, 1'b0, 1'b1};
							res_en  = 1'b1;
							state_d = S_EMIT;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_CALC: begin
				if (range_bad) begin
					res_d   = '{ST_OUT_OF_RANGE, 32'd0, 33'd0, 1'b0, 1'b1};
					res_en  = 1'b1;
					state_d = S_EMIT;
				end else begin
					rem_d   = count_q;
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				// keep one read in flight ahead of the compare
				if (rem_q != '0) begin
					mreq.re = 1'b1;
					rem_d   = rem_q - CNT_W'(1);
				end
				res_d = '{ST_CONTAINED, s_q, add_len, 1'b0, 1'b1};
				if (contain) begin
					res_en  = 1'b1;
					state_d = S_EMIT;
				end else if (touch) begin
					mreq.we     = 1'b1;
					mreq.waddr  = cmp_idx_s1;
					mreq.wstart = (s_q < rd_start) ? s_q : rd_start;
					mreq.wend   = (e_q > rd_end) ? e_q : rd_end;
					res_d.status = ST_MERGED;
					res_en  = 1'b1;
					state_d = S_EMIT;
				end else if (exhausted) begin
					if (count_q == CNT_W'(MAX_RANGES)) begin
						res_d.status = ST_FULL;
					end else begin
						mreq.we     = 1'b1;
						mreq.waddr  = count_q[IDX_W-1:0];
						mreq.wstart = s_q;
						mreq.wend   = e_q;
						count_d     = count_q + CNT_W'(1);
						res_d.status = ST_INSERTED;
					end
					res_en  = 1'b1;
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_SYNC_RD: begin
				if (rem_q == '0) begin
					// empty table
					load_res = '{ST_EMPTY, 32'd0, 33'd0, wait_q, 1'b1};
					if (slot_free) begin
						out_load = 1'b1;
						state_d  = S_IDLE;
					end
				end else begin
					mreq.re = 1'b1;
					rem_d   = rem_q - CNT_W'(1);
					state_d = S_SYNC_WAIT;
				end
			end
			S_SYNC_WAIT: begin
				load_res = '{ST_RANGE, rd_start, 33'(rd_end - END_W'(rd_start)),
					wait_q, (rem_q == '0)};
				if (slot_free) begin
					out_load = 1'b1;
					if (rem_q == '0) begin
						count_d = '0;
						state_d = S_IDLE;
					end else begin
						state_d = S_SYNC_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			base_q   <= '0;
			count_q  <= '0;
			rem_q    <= '0;
			cmp_v_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			rem_q    <= rem_d;
			cmp_v_s1 <= mreq.re && (state_q == S_SEARCH);
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
		end
	end

	// item and search payload
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= mreq.raddr;
		if (accept) begin
			below_q <= (address < base_q);
			rel_q   <= address - base_q;
			len_q   <= length;
			wait_q  <= wait_req;
		end
		if (state_q == S_CALC) begin
			s_q <= s_c;
			e_q <= e_c;
		end
		if (res_en) begin
			res_q <= res_d;
		end
	end

	drt_mem u_mem (
		.clk      (clk),
		.req      (mreq),
		.rd_start (rd_start),
		.rd_end   (rd_end)
	);

	drt_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (out_load),
		.res_i     (load_res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res_o     (out_res),
		.free      (slot_free)
	);

	assign status       = out_res.status;
	assign range_offset = out_res.offset;
	assign range_length = out_res.length;
	assign wait_flag    = out_res.wait_f;
	assign last         = out_res.last;

endmodule

// File: rtl/core/drt_mem.sv
module drt_mem
	import drt_pkg::*;
(
	input  logic             clk,
	input  mem_req_t         req,
	output logic [31:0]      rd_start,
	output logic [END_W-1:0] rd_end
);

	logic [31:0]      start_mem [MAX_RANGES];
	logic [END_W-1:0] end_mem   [MAX_RANGES];

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			start_mem[req.waddr] <= req.wstart;
			end_mem[req.waddr]   <= req.wend;
		end
	end

	// registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_start <= start_mem[req.raddr];
			rd_end   <= end_mem[req.raddr];
		end
	end

endmodule

// File: rtl/core/drt_out_reg.sv
module drt_out_reg
	import drt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res_i,
	input  logic out_stall,
	output logic out_valid,
	output res_t res_o,
	output logic free
);

	logic valid_q;
	res_t res_q;

	// slot is free when empty or being taken this cycle
	assign free      = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign res_o     = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (free) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_i;
		end
	end

endmodule

// File: rtl/core/drt_chk.sv
`include "dirty_range_tracker_assert.svh"

module drt_chk
	import drt_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [31:0] range_offset,
	input logic [32:0] range_length,
	input logic        wait_flag,
	input logic        last
);

	// stalled result holds
	`DRT_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(range_offset) && $stable(range_length) && $stable(status),
		"stalled result changed")

	// only range items of a sync can be non-final
	`DRT_ASSERT_IMPL(a_last_mark, out_valid && (status != ST_RANGE), last,
		"non-range item without last mark")

	// wait flag only on sync results
	`DRT_ASSERT_IMPL(a_wait_sync, out_valid && wait_flag,
		(status == ST_RANGE) || (status == ST_EMPTY), "wait flag outside sync")

	// status items without a range carry zero bounds
	`DRT_ASSERT_IMPL(a_zero_range,
		out_valid && ((status == ST_OUT_OF_RANGE) || (status == ST_EMPTY) ||
		(status == ST_FLUSHED)),
		(range_offset == 32'd0) && (range_length == 33'd0), "bounds on a status-only item")

endmodule

bind dirty_range_tracker drt_chk u_chk (.*);
